### sv/assert_macros.svh
// Assertion macros shared by the checker files.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define LFC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define LFC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### sv/lfc_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types of the Laplacian filter.
// No dependencies; imported by the top level, lfc_front, lfc_jobq and lfc_back.
package lfc_pkg;

    localparam int MAX_WIDTH     = 2048;
    localparam int PIXEL_BITS    = 16;
    localparam int FRAC_BITS     = 16;
    localparam int ADDR_BITS     = $clog2(MAX_WIDTH);
    localparam int W_BITS        = 12;
    localparam int H_BITS        = 13;
    localparam int CFG_DATA_BITS = 13;
    localparam int OUT_BITS      = 32;
    localparam int WIN           = 5;

    // Accumulator and magnitude widths; the 5x5 kernel has weight sum 64.
    localparam int ACC_BITS  = PIXEL_BITS + 7;
    localparam int MAG_BITS  = ACC_BITS - 1;
    // Magnitudes of the 8-shaped kernel stay below 24 * 2^(PIXEL_BITS-1).
    localparam int MAG3_BITS = PIXEL_BITS + 4;
    localparam int REC_SHIFT = MAG3_BITS + 2;
    localparam int REC_BITS  = REC_SHIFT - 1;
    localparam int REC_MULT  = (2 ** REC_SHIFT + 2) / 3;
    localparam int A_BITS    = MAG3_BITS - 1;
    localparam int Q_BITS    = OUT_BITS + 1;

    localparam int JQ_DEPTH = 4;
    localparam int OQ_DEPTH = 8;

    localparam logic [1:0] REG_KERNEL_SELECT = 2'd0;
    localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd1;
    localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd2;

    localparam logic [1:0] KS_CROSS4   = 2'd0;
    localparam logic [1:0] KS_UNIFORM8 = 2'd1;
    localparam logic [1:0] KS_SHAPED8  = 2'd2;
    localparam logic [1:0] KS_WIDE5    = 2'd3;

    typedef logic signed [PIXEL_BITS-1:0] pix_t;
    typedef pix_t [WIN-1:0][WIN-1:0] win_t;

    typedef struct packed {
        logic                 valid;
        logic [1:0]           index;
        logic [CFG_DATA_BITS-1:0] data;
    } cfg_wr_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0] x0;
        logic [1:0]           cnt;
        logic [ADDR_BITS-1:0] col;
        logic [H_BITS-1:0]    rin;
        logic [H_BITS-1:0]    y;
        logic [W_BITS-1:0]    w;
        logic [H_BITS-1:0]    h;
        logic [1:0]           ks;
    } job_meta_t;

    typedef struct packed {
        win_t      win;
        job_meta_t meta;
    } job_t;

    typedef struct packed {
        logic [OUT_BITS-1:0] value;
        logic                row_end;
        logic                frame_end;
        logic                run_last;
    } res_t;

endpackage

### sv/laplacian_filter_clamped.sv
`timescale 1ns / 1ps
// Top level of the streaming Laplacian filter with edge clamping.
// Depends on lfc_pkg, lfc_front, lfc_jobq, lfc_back.
//
// The filter takes one pixel per clock in raster order while full is low and,
// once the kernel radius worth of rows has arrived, gives one result per input
// column; the last input of a row also gives the trailing columns, so such an
// item yields two (3x3 kernels) or three (5x5 kernel) results. The result side
// drains one result per clock while it is popped and not empty, so row ends put
// the output behind the input; a job queue of four windows and an eight-entry
// result queue absorb that and any short stall on either side. The first result
// of an item passes through the line store read, the window shift and queueing,
// four arithmetic stages and the write into the result queue. The line store is
// four banks of 2048 x 16 bits with no reset and no clearing pass, so the block
// accepts items straight out of reset. Write registers only while idle.
module laplacian_filter_clamped
    import lfc_pkg::*;
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic signed [PIXEL_BITS-1:0]    pixel_value,
    input  logic                            pad_item,
    output logic                            empty,
    input  logic                            pop,
    output logic signed [OUT_BITS-1:0]      filtered_value,
    output logic                            row_end,
    output logic                            frame_end,
    output logic                            run_last,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [1:0]                      cfg_index,
    input  logic [CFG_DATA_BITS-1:0]        cfg_data
);

    cfg_wr_t cfg_wr;
    logic    job_push;
    job_t    job_in;
    logic    job_valid;
    job_t    job_head;
    logic    job_pop;
    res_t    res;

    assign cfg_ready    = 1'b1;
    assign cfg_wr.valid = cfg_valid && cfg_ready;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_data;

    lfc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_wr),
        .push        (push),
        .full        (full),
        .pixel_value (pixel_value),
        .pad_item    (pad_item),
        .job_pop     (job_pop),
        .job_push    (job_push),
        .job         (job_in)
    );

    lfc_jobq u_jobq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .din   (job_in),
        .pop   (job_pop),
        .valid (job_valid),
        .dout  (job_head)
    );

    lfc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (job_head),
        .job_pop   (job_pop),
        .pop       (pop),
        .empty     (empty),
        .res       (res)
    );

    assign filtered_value = signed'(res.value);
    assign row_end        = res.row_end;
    assign frame_end      = res.frame_end;
    assign run_last       = res.run_last;

endmodule

### sv/lfc_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the line store banks.
module lfc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // A read of the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/lfc_front.sv
`timescale 1ns / 1ps
// Front end: configuration registers, raster counters, line store and window.
// Depends on lfc_pkg and lfc_ram; hands finished windows to the job queue.
module lfc_front (
    input  logic            clk,
    input  logic            rst_n,
    input  lfc_pkg::cfg_wr_t cfg,
    input  logic            push,
    output logic            full,
    input  lfc_pkg::pix_t   pixel_value,
    input  logic            pad_item,
    input  logic            job_pop,
    output logic            job_push,
    output lfc_pkg::job_t   job
);
    import lfc_pkg::*;

    localparam int JQ_CNT_BITS = $clog2(JQ_DEPTH + 1);

    logic [1:0]             ks_reg;
    logic [W_BITS-1:0]      width_reg;
    logic [H_BITS-1:0]      height_reg;
    logic [ADDR_BITS-1:0]   col_reg;
    logic [H_BITS-1:0]      row_reg;
    logic [JQ_CNT_BITS-1:0] jq_used_reg;

    logic [W_BITS-1:0]    w_eff;
    logic [H_BITS-1:0]    h_eff;
    logic [1:0]           rad;
    logic [H_BITS:0]      h_lim;
    logic                 clear;
    logic [ADDR_BITS-1:0] c;
    logic [H_BITS-1:0]    rin;
    logic                 drain;
    logic                 drop;
    logic                 accept;
    logic                 last;
    logic                 c_ge_r;
    logic                 produce;
    logic [ADDR_BITS-1:0] x0;
    logic [1:0]           cnt;
    logic [W_BITS-1:0]    col_inc;
    logic [H_BITS:0]      row_inc;
    logic                 ram_we;
    pix_t                 bank_rd [4];

    logic       b_valid_reg;
    logic       b_produce_reg;
    logic       b_drain_reg;
    pix_t       b_pix_reg;
    logic [1:0] b_bank_reg;
    job_meta_t  b_meta_reg;
    win_t       win_reg;
    win_t       win_next;
    pix_t       col_in [WIN];

    always_comb
    begin
        if (width_reg == '0)
            w_eff = W_BITS'(1);
        else if (width_reg > W_BITS'(MAX_WIDTH))
            w_eff = W_BITS'(MAX_WIDTH);
        else
            w_eff = width_reg;
        h_eff  = (height_reg == '0) ? H_BITS'(1) : height_reg;
        rad    = (ks_reg == KS_WIDE5) ? 2'd2 : 2'd1;
        h_lim  = {1'b0, h_eff} + (H_BITS + 1)'(rad);
        // Counters left outside the geometry by a register change restart the frame.
        clear  = ({1'b0, col_reg} >= w_eff) || ({1'b0, row_reg} >= h_lim);
        c      = clear ? '0 : col_reg;
        rin    = clear ? '0 : row_reg;
        drain  = rin >= h_eff;
        drop   = pad_item && !drain;
        accept = push && !full;
        last   = ({1'b0, c} == (w_eff - W_BITS'(1)));
        c_ge_r = c >= ADDR_BITS'(rad);
        produce = !drop && (rin >= H_BITS'(rad)) && (last || c_ge_r);
        x0     = c_ge_r ? (c - ADDR_BITS'(rad)) : '0;
        cnt    = last ? (2'(c - x0) + 2'd1) : 2'd1;
        col_inc = {1'b0, c} + W_BITS'(1);
        row_inc = {1'b0, rin} + (H_BITS + 1)'(1);
        ram_we = accept && !drop && !drain;
        full   = jq_used_reg >= JQ_CNT_BITS'(JQ_DEPTH);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ks_reg      <= KS_CROSS4;
            width_reg   <= W_BITS'(640);
            height_reg  <= H_BITS'(480);
            col_reg     <= '0;
            row_reg     <= '0;
            jq_used_reg <= '0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_KERNEL_SELECT: ks_reg     <= cfg.data[1:0];
                    REG_IMAGE_WIDTH:   width_reg  <= cfg.data[W_BITS-1:0];
                    REG_IMAGE_HEIGHT:  height_reg <= cfg.data;
                    default: ;
                endcase
            end
            if (accept)
            begin
                if (drop)
                begin
                    col_reg <= c;
                    row_reg <= rin;
                end
                else if (col_inc >= w_eff)
                begin
                    col_reg <= '0;
                    row_reg <= (row_inc >= h_lim) ? '0 : row_inc[H_BITS-1:0];
                end
                else
                begin
                    col_reg <= col_inc[ADDR_BITS-1:0];
                    row_reg <= rin;
                end
            end
            jq_used_reg <= jq_used_reg + JQ_CNT_BITS'(accept && produce)
                           - JQ_CNT_BITS'(job_pop);
            b_valid_reg <= accept && !drop;
        end
    end

    always_ff @(posedge clk)
    begin
        b_produce_reg   <= produce;
        b_drain_reg     <= drain;
        b_pix_reg       <= pixel_value;
        b_bank_reg      <= rin[1:0];
        b_meta_reg.x0   <= x0;
        b_meta_reg.cnt  <= cnt;
        b_meta_reg.col  <= c;
        b_meta_reg.rin  <= rin;
        b_meta_reg.y    <= rin - H_BITS'(rad);
        b_meta_reg.w    <= w_eff;
        b_meta_reg.h    <= h_eff;
        b_meta_reg.ks   <= ks_reg;
    end

    // One bank per line; each line lives in the bank of its row number mod 4.
    for (genvar b = 0; b < 4; b++)
    begin : gen_bank
        lfc_ram #(
            .WIDTH (PIXEL_BITS),
            .DEPTH (MAX_WIDTH)
        ) u_bank (
            .clk   (clk),
            .we    (ram_we && (rin[1:0] == 2'(b))),
            .waddr (c),
            .wdata (pixel_value),
            .raddr (c),
            .rdata (bank_rd[b])
        );
    end

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            col_in[k] = bank_rd[2'(b_bank_reg + 2'(k))];
        end
        col_in[4] = b_drain_reg ? '0 : b_pix_reg;
        for (int i = 0; i < WIN; i++)
        begin
            for (int j = 0; j < WIN - 1; j++)
            begin
                win_next[i][j] = win_reg[i][j+1];
            end
            win_next[i][WIN-1] = col_in[i];
        end
        job_push = b_valid_reg && b_produce_reg;
        job.win  = win_next;
        job.meta = b_meta_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (b_valid_reg)
        begin
            win_reg <= win_next;
        end
    end

endmodule

### sv/lfc_jobq.sv
`timescale 1ns / 1ps
// Short queue of window jobs between the front end and the arithmetic back end.
// Depends on lfc_pkg.
module lfc_jobq (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  lfc_pkg::job_t din,
    input  logic          pop,
    output logic          valid,
    output lfc_pkg::job_t dout
);
    import lfc_pkg::*;

    localparam int PTR_BITS = $clog2(JQ_DEPTH);
    localparam int CNT_BITS = $clog2(JQ_DEPTH + 1);

    job_t                mem_reg [JQ_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;

    assign valid = count_reg != '0;
    assign dout  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PTR_BITS'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_BITS'(1);
            count_reg <= count_reg + CNT_BITS'(push) - CNT_BITS'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= din;
    end

endmodule

### sv/lfc_back.sv
`timescale 1ns / 1ps
// Back end: walks the output columns of each job, convolves, normalizes, queues results.
// Depends on lfc_pkg.
module lfc_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_valid,
    input  lfc_pkg::job_t job,
    output logic          job_pop,
    input  logic          pop,
    output logic          empty,
    output lfc_pkg::res_t res
);
    import lfc_pkg::*;

    localparam int OQ_PTR_BITS = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_BITS = $clog2(OQ_DEPTH + 1);
    localparam int IDX_BITS    = 15;

    // Fraction left by the remainder of a division by three, rounded as the kernel needs.
    function automatic logic [FRAC_BITS-1:0] third_frac(input logic [1:0] rem);
        logic [FRAC_BITS-1:0] f;
        case (rem)
            2'd1:    f = FRAC_BITS'((2 ** FRAC_BITS + 12) / 24);
            2'd2:    f = FRAC_BITS'((2 * 2 ** FRAC_BITS + 12) / 24);
            default: f = '0;
        endcase
        return f;
    endfunction

    logic [1:0]             k_reg;
    logic [OQ_CNT_BITS-1:0] oq_used_reg;
    logic                   issue;
    logic                   last_k;
    logic [ADDR_BITS-1:0]   x;
    logic [2:0]             ri [WIN];
    logic [2:0]             ci [WIN];
    win_t                   gath;

    logic signed [IDX_BITS-1:0] ys, yt, hmax, xs, xt, wmax;

    logic       s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    win_t       s1_g_reg;
    logic [1:0] s1_ks_reg, s2_ks_reg, s3_ks_reg;
    logic [2:0] s1_flags_reg, s2_flags_reg, s3_flags_reg, s4_flags_reg;

    logic signed [ACC_BITS-1:0] ctr, e_sum, d_sum, o_sum, acc;
    logic signed [ACC_BITS-1:0] s2_acc_reg;

    logic                          neg;
    logic [MAG_BITS-1:0]           mag;
    logic                          s3_neg_reg, s4_neg_reg;
    logic [MAG_BITS-1:0]           s3_mag_reg;
    logic [MAG3_BITS+REC_BITS-1:0] s3_prod_reg;

    logic [A_BITS-1:0]    a_div;
    logic [MAG3_BITS-1:0] rem;
    logic [Q_BITS-1:0]    q;
    logic [Q_BITS-1:0]    s4_q_reg;

    logic [Q_BITS-1:0] qs;
    logic [Q_BITS-1:0] qn;
    res_t              wr_res;

    res_t                   oq_mem [OQ_DEPTH];
    logic [OQ_PTR_BITS-1:0] oq_wr_reg;
    logic [OQ_PTR_BITS-1:0] oq_rd_reg;
    logic [OQ_CNT_BITS-1:0] oq_cnt_reg;
    logic                   pop_acc;

    // Issue one output column per cycle while a job waits and a result queue slot is free.
    always_comb
    begin
        issue   = job_valid && (oq_used_reg < OQ_CNT_BITS'(OQ_DEPTH));
        last_k  = k_reg == (job.meta.cnt - 2'd1);
        job_pop = issue && last_k;
        x       = job.meta.x0 + ADDR_BITS'(k_reg);
        hmax    = signed'({2'b00, job.meta.h}) - IDX_BITS'(1);
        wmax    = signed'({3'b000, job.meta.w}) - IDX_BITS'(1);
        for (int i = 0; i < WIN; i++)
        begin
            ys = signed'({2'b00, job.meta.y}) + IDX_BITS'(i - 2);
            if (ys < 0)
                ys = '0;
            else if (ys > hmax)
                ys = hmax;
            yt = ys - signed'({2'b00, job.meta.rin}) + IDX_BITS'(4);
            if (yt < 0)
                yt = '0;
            else if (yt > IDX_BITS'(4))
                yt = IDX_BITS'(4);
            ri[i] = yt[2:0];
        end
        for (int j = 0; j < WIN; j++)
        begin
            xs = signed'({4'b0000, x}) + IDX_BITS'(j - 2);
            if (xs < 0)
                xs = '0;
            else if (xs > wmax)
                xs = wmax;
            xt = xs - signed'({4'b0000, job.meta.col}) + IDX_BITS'(4);
            if (xt < 0)
                xt = '0;
            else if (xt > IDX_BITS'(4))
                xt = IDX_BITS'(4);
            ci[j] = xt[2:0];
        end
        for (int i = 0; i < WIN; i++)
        begin
            for (int j = 0; j < WIN; j++)
            begin
                gath[i][j] = job.win[ri[i]][ci[j]];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg        <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (issue)
                k_reg <= last_k ? 2'd0 : (k_reg + 2'd1);
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_g_reg        <= gath;
        s1_ks_reg       <= job.meta.ks;
        s1_flags_reg[2] <= ({1'b0, x} == (job.meta.w - W_BITS'(1)));
        s1_flags_reg[1] <= ({1'b0, x} == (job.meta.w - W_BITS'(1)))
                           && (job.meta.y == (job.meta.h - H_BITS'(1)));
        s1_flags_reg[0] <= last_k;
    end

    // Weighted sum with constant weights; taps are indexed as [dy+2][dx+2].
    always_comb
    begin
        ctr   = ACC_BITS'(s1_g_reg[2][2]);
        e_sum = ACC_BITS'(s1_g_reg[1][2]) + ACC_BITS'(s1_g_reg[2][1])
              + ACC_BITS'(s1_g_reg[2][3]) + ACC_BITS'(s1_g_reg[3][2]);
        d_sum = ACC_BITS'(s1_g_reg[1][1]) + ACC_BITS'(s1_g_reg[1][3])
              + ACC_BITS'(s1_g_reg[3][1]) + ACC_BITS'(s1_g_reg[3][3]);
        o_sum = ACC_BITS'(s1_g_reg[0][2]) + ACC_BITS'(s1_g_reg[2][0])
              + ACC_BITS'(s1_g_reg[2][4]) + ACC_BITS'(s1_g_reg[4][2]);
        case (s1_ks_reg)
            KS_CROSS4:   acc = (ctr <<< 2) - e_sum;
            KS_UNIFORM8: acc = (ctr <<< 3) - e_sum - d_sum;
            KS_SHAPED8:  acc = (ctr <<< 3) + (ctr <<< 2) - d_sum - (e_sum <<< 1);
            default:     acc = (ctr <<< 4) + (ctr <<< 2) - (e_sum <<< 3)
                               + (d_sum <<< 1) + o_sum;
        endcase
    end

    always_ff @(posedge clk)
    begin
        s2_acc_reg   <= acc;
        s2_ks_reg    <= s1_ks_reg;
        s2_flags_reg <= s1_flags_reg;
    end

    // Magnitude and the reciprocal product used to divide by three.
    always_comb
    begin
        neg = s2_acc_reg < 0;
        mag = neg ? MAG_BITS'(-s2_acc_reg) : MAG_BITS'(s2_acc_reg);
    end

    always_ff @(posedge clk)
    begin
        s3_neg_reg   <= neg;
        s3_mag_reg   <= mag;
        s3_prod_reg  <= mag[MAG3_BITS-1:0] * REC_BITS'(REC_MULT);
        s3_ks_reg    <= s2_ks_reg;
        s3_flags_reg <= s2_flags_reg;
    end

    // Normalized magnitude: a shift for power-of-two sums, quotient and remainder for 24.
    always_comb
    begin
        a_div = s3_prod_reg[REC_SHIFT +: A_BITS];
        rem   = s3_mag_reg[MAG3_BITS-1:0]
              - (MAG3_BITS'(a_div) + MAG3_BITS'({a_div, 1'b0}));
        case (s3_ks_reg)
            KS_CROSS4:   q = Q_BITS'(s3_mag_reg) << (FRAC_BITS - 3);
            KS_UNIFORM8: q = Q_BITS'(s3_mag_reg) << (FRAC_BITS - 4);
            KS_SHAPED8:  q = (Q_BITS'(a_div) << (FRAC_BITS - 3))
                             + Q_BITS'(third_frac(rem[1:0]));
            default:     q = Q_BITS'(s3_mag_reg) << (FRAC_BITS - 6);
        endcase
    end

    always_ff @(posedge clk)
    begin
        s4_q_reg     <= q;
        s4_neg_reg   <= s3_neg_reg;
        s4_flags_reg <= s3_flags_reg;
    end

    // Saturate to the signed output range and restore the sign.
    always_comb
    begin
        if (!s4_neg_reg)
        begin
            qs = (s4_q_reg > Q_BITS'({1'b0, {(OUT_BITS-1){1'b1}}}))
               ? Q_BITS'({1'b0, {(OUT_BITS-1){1'b1}}}) : s4_q_reg;
            qn = qs;
        end
        else
        begin
            qs = (s4_q_reg > Q_BITS'({1'b1, {(OUT_BITS-1){1'b0}}}))
               ? Q_BITS'({1'b1, {(OUT_BITS-1){1'b0}}}) : s4_q_reg;
            qn = '0 - qs;
        end
        wr_res.value     = qn[OUT_BITS-1:0];
        wr_res.row_end   = s4_flags_reg[2];
        wr_res.frame_end = s4_flags_reg[1];
        wr_res.run_last  = s4_flags_reg[0];
    end

    assign empty   = oq_cnt_reg == '0;
    assign res     = oq_mem[oq_rd_reg];
    assign pop_acc = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg   <= '0;
            oq_rd_reg   <= '0;
            oq_cnt_reg  <= '0;
            oq_used_reg <= '0;
        end
        else
        begin
            if (s4_valid_reg)
                oq_wr_reg <= oq_wr_reg + OQ_PTR_BITS'(1);
            if (pop_acc)
                oq_rd_reg <= oq_rd_reg + OQ_PTR_BITS'(1);
            oq_cnt_reg  <= oq_cnt_reg + OQ_CNT_BITS'(s4_valid_reg) - OQ_CNT_BITS'(pop_acc);
            oq_used_reg <= oq_used_reg + OQ_CNT_BITS'(issue) - OQ_CNT_BITS'(pop_acc);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s4_valid_reg)
            oq_mem[oq_wr_reg] <= wr_res;
    end

endmodule

### sv/lfc_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the Laplacian filter, bound to the top level.
// Depends on assert_macros.svh and the top level laplacian_filter_clamped.
`include "assert_macros.svh"

module lfc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [31:0] filtered_value,
    input logic        row_end,
    input logic        frame_end,
    input logic        run_last
);

    // A result waiting to be taken does not change.
    `LFC_ASSERT_NXT(a_result_holds, clk, rst_n, !empty && !pop, !empty && $stable(filtered_value) && $stable(row_end) && $stable(frame_end) && $stable(run_last))

    // The last column of a row is always the final result of its item.
    `LFC_ASSERT_IMP(a_row_end_last, clk, rst_n, !empty && row_end, run_last)

    // The frame ends only at a row end.
    `LFC_ASSERT_IMP(a_frame_in_row, clk, rst_n, !empty && frame_end, row_end)

endmodule

bind laplacian_filter_clamped lfc_checker u_lfc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .empty          (empty),
    .pop            (pop),
    .filtered_value (filtered_value),
    .row_end        (row_end),
    .frame_end      (frame_end),
    .run_last       (run_last)
);
